// ----- sv/tabq_pkg.sv -----
// Shared types and constants for the three-axis biquad filter.
package tabq_pkg;

  localparam int CHANNELS        = 3;
  localparam int COEF_WIDTH      = 16;
  localparam int SHIFT_WIDTH     = 4;
  localparam int ROUND_WIDTH     = 15;
  localparam int REG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Channel slots inside the lane array
  localparam int CH_P = 0;
  localparam int CH_Q = 1;
  localparam int CH_R = 2;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_COEF_A0    = 3'd0,
    REG_COEF_A1    = 3'd1,
    REG_COEF_A2    = 3'd2,
    REG_COEF_B1    = 3'd3,
    REG_COEF_B2    = 3'd4,
    REG_FRAC_SHIFT = 3'd5,
    REG_ROUND_ADD  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] a0;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] a2;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic [SHIFT_WIDTH-1:0]       frac_shift;
    logic [ROUND_WIDTH-1:0]       round_add;
  } coef_t;

  localparam logic [SHIFT_WIDTH-1:0] FRAC_SHIFT_RESET = 4'd14;
  localparam logic [ROUND_WIDTH-1:0] ROUND_ADD_RESET  = 15'd8192;

endpackage

// ----- sv/tabq_regs.sv -----
// Configuration register file: coefficients, shift and rounding constant.
module tabq_regs import tabq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       write,
  input  logic [REG_INDEX_WIDTH-1:0] index,
  input  logic [CFG_DATA_WIDTH-1:0]  data,
  output coef_t                      coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a0         <= '0;
      coef.a1         <= '0;
      coef.a2         <= '0;
      coef.b1         <= '0;
      coef.b2         <= '0;
      coef.frac_shift <= FRAC_SHIFT_RESET;
      coef.round_add  <= ROUND_ADD_RESET;
    end else if (write) begin
      case (reg_index_t'(index))
        REG_COEF_A0:    coef.a0         <= data[COEF_WIDTH-1:0];
        REG_COEF_A1:    coef.a1         <= data[COEF_WIDTH-1:0];
        REG_COEF_A2:    coef.a2         <= data[COEF_WIDTH-1:0];
        REG_COEF_B1:    coef.b1         <= data[COEF_WIDTH-1:0];
        REG_COEF_B2:    coef.b2         <= data[COEF_WIDTH-1:0];
        REG_FRAC_SHIFT: coef.frac_shift <= data[SHIFT_WIDTH-1:0];
        REG_ROUND_ADD:  coef.round_add  <= data[ROUND_WIDTH-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

// ----- sv/tabq_lane.sv -----
// One channel's direct-form-I biquad section with its own history.
module tabq_lane import tabq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  coef_t                          coef,
  input  logic                           load,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = TERM_W + 3;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x1, x2, y1, y2;

  logic signed [COEF_WIDTH-1:0]   mul_coef [5];
  logic signed [SAMPLE_WIDTH-1:0] mul_val  [5];
  logic signed [PROD_W-1:0]       prod     [5];
  logic signed [TERM_W-1:0]       term     [5];
  logic signed [TERM_W-1:0]       round_ext;
  logic signed [SUM_W-1:0]        sum;

  assign mul_coef[0] = coef.a0;  assign mul_val[0] = sample;
  assign mul_coef[1] = coef.a1;  assign mul_val[1] = x1;
  assign mul_coef[2] = coef.a2;  assign mul_val[2] = x2;
  assign mul_coef[3] = coef.b1;  assign mul_val[3] = y1;
  assign mul_coef[4] = coef.b2;  assign mul_val[4] = y2;

  assign round_ext = TERM_W'($signed({1'b0, coef.round_add}));

  // Full product, rounding constant, then floor shift (>>> on signed)
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      prod[i] = PROD_W'(mul_coef[i]) * PROD_W'(mul_val[i]);
      term[i] = (TERM_W'(prod[i]) + round_ext) >>> coef.frac_shift;
    end
  end

  assign sum = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2])
             - SUM_W'(term[3]) - SUM_W'(term[4]);

  always_comb begin
    if (sum > SUM_W'(SAT_MAX))      result = SAT_MAX;
    else if (sum < SUM_W'(SAT_MIN)) result = SAT_MIN;
    else                            result = sum[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (load) begin
      x2 <= x1;
      x1 <= sample;
      y2 <= y1;
      y1 <= result;
    end
  end

endmodule

// ----- sv/three_axis_biquad_filter.sv -----
// Top level: three parallel biquad lanes, config registers and output queue.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid/in_ready   | sample_p, sample_q, sample_r
//   out     | out_valid/out_ready | filtered_p, filtered_q, filtered_r
//   cfg     | cfg_valid/cfg_ready | cfg_index (register number), cfg_data
//
// Throughput is one item per cycle while in_ready is high; with the queue
// empty a result shows on the outputs in the cycle after its item is
// accepted, otherwise it waits behind the result already held. The rate is
// set by each lane's combinational path (five products, round, shift, sum,
// saturate) that also feeds the output history back for the next item.
// Synchronous reset clears the filter history, the coefficients and the queue;
// the shift and rounding constant return to their reset values. The results
// go into a two-entry queue, so input is still taken while one result waits;
// in_ready drops only when both entries are held. cfg_ready is always high.
module three_axis_biquad_filter import tabq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_p,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_r,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_p,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_q,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_r,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [REG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

  coef_t coef;
  logic  push, pop;

  logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_in, lane_out;
  logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] head, tail;  // queue entries
  logic [1:0] count, count_next;

  assign cfg_ready = 1'b1;

  tabq_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .write (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .coef  (coef)
  );

  assign lane_in[CH_P] = sample_p;
  assign lane_in[CH_Q] = sample_q;
  assign lane_in[CH_R] = sample_r;

  // One lane per channel; history advances only on an accepted item
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    tabq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .coef   (coef),
      .load   (push),
      .sample (lane_in[c]),
      .result (lane_out[c])
    );
  end

  // Merge stage: the lane results travel together as one queue entry
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop)      count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) head <= tail;
      else if (push)     head <= lane_out;
    end else if (push) begin
      if (count == 2'd0) head <= lane_out;
      else               tail <= lane_out;
    end
  end

  assign filtered_p = head[CH_P];
  assign filtered_q = head[CH_Q];
  assign filtered_r = head[CH_R];

endmodule

// ----- sv/tabq_check.sv -----
// Port-level checks for the three-axis biquad filter, bound to the top level.
module tabq_check #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] filtered_p,
  input logic signed [SAMPLE_WIDTH-1:0] filtered_q,
  input logic signed [SAMPLE_WIDTH-1:0] filtered_r
);

  // A held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_p)
      && $stable(filtered_q) && $stable(filtered_r))
    else $error("result changed or dropped while stalled");

  // Nothing is left in the queue after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("queue not empty after reset");

  // An item taken into an empty output shows in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after accept");

  // Input back-pressure only when results are pending
  a_full_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind three_axis_biquad_filter tabq_check #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_check (.*);
